FILE: rtl/ale_pkg.sv
// Package for the array list engine: item types, command/status codes,
// state encoding and per-cell control. No dependencies.
`default_nettype none
package ale_pkg;

    // Default list capacity and reset value of the limit register
    localparam int          CAPACITY_DEF = 64;
    localparam logic [6:0]  LIMIT_RESET  = 7'd64;

    // Field widths fixed by the item format
    localparam int VALUE_W = 32;
    localparam int INDEX_W = 6;
    localparam int CMD_W   = 3;
    localparam int STAT_W  = 3;
    localparam int HELD_W  = 7;
    localparam int LIMIT_W = 7;

    typedef enum logic [CMD_W-1:0] {
        CMD_INSERT_AT    = 3'd0,
        CMD_INSERT_FIRST = 3'd1,
        CMD_INSERT_LAST  = 3'd2,
        CMD_REMOVE_AT    = 3'd3,
        CMD_REMOVE_FIRST = 3'd4,
        CMD_REMOVE_LAST  = 3'd5,
        CMD_SEARCH       = 3'd6,
        CMD_CLEAR        = 3'd7
    } cmd_t;

    typedef enum logic [STAT_W-1:0] {
        STAT_OK        = 3'd0,
        STAT_FULL      = 3'd1,
        STAT_EMPTY     = 3'd2,
        STAT_BAD_INDEX = 3'd3,
        STAT_NOT_FOUND = 3'd4
    } status_t;

    typedef enum logic [1:0] {
        S_IDLE = 2'd0,
        S_EXEC = 2'd1,
        S_DONE = 2'd2
    } state_t;

    typedef enum logic [1:0] {
        OP_HOLD   = 2'd0,
        OP_INSERT = 2'd1,
        OP_REMOVE = 2'd2
    } cell_op_t;

    // Control broadcast to every cell of the row
    typedef struct packed {
        logic                       exec;
        cell_op_t                   op;
        logic signed [VALUE_W-1:0]  value;
    } cell_ctl_t;

    typedef struct packed {
        logic [CMD_W-1:0]           command;
        logic signed [VALUE_W-1:0]  value;
        logic [INDEX_W-1:0]         index;
    } in_item_t;

    typedef struct packed {
        logic signed [VALUE_W-1:0]  removed_value;
        logic [INDEX_W-1:0]         found_position;
        logic [STAT_W-1:0]          status;
        logic [HELD_W-1:0]          entries_held;
    } out_item_t;

endpackage
`default_nettype wire

FILE: rtl/ale_cell.sv
// One list cell: holds one entry, shifts to/from its neighbors,
// compares against the search value. Depends on ale_pkg.
`default_nettype none
module ale_cell
    import ale_pkg::*;
#(
    parameter int POS_W = 6,
    parameter int CNT_W = 7,
    parameter int IDX   = 0
)
(
    input  wire logic                       clk,
    input  wire cell_ctl_t                  ctl,
    input  wire logic [POS_W-1:0]           pos,
    input  wire logic [CNT_W-1:0]           count,
    input  wire logic signed [VALUE_W-1:0]  left_data,
    input  wire logic signed [VALUE_W-1:0]  right_data,
    output logic signed [VALUE_W-1:0]       data,
    output logic                            match,
    output logic signed [VALUE_W-1:0]       pick
);

    localparam logic [POS_W-1:0] MY_POS = POS_W'(IDX);
    localparam logic [CNT_W-1:0] MY_CNT = CNT_W'(IDX);

    logic signed [VALUE_W-1:0] data_reg, data_next;
    logic                      match_reg, match_next;
    logic signed [VALUE_W-1:0] pick_reg, pick_next;

    // Shift / load of the held entry
    always_comb
    begin
        data_next = data_reg;
        if (ctl.exec)
        begin
            case (ctl.op)
                OP_INSERT:
                begin
                    if (MY_POS == pos)
                        data_next = ctl.value;
                    else if (MY_POS > pos)
                        data_next = left_data;
                end
                OP_REMOVE:
                begin
                    if (MY_POS >= pos)
                        data_next = right_data;
                end
                default: data_next = data_reg;
            endcase
        end
    end

    // Compare and pick use the contents before the shift
    always_comb
    begin
        match_next = match_reg;
        pick_next  = pick_reg;
        if (ctl.exec)
        begin
            match_next = (data_reg == ctl.value) && (MY_CNT < count);
            pick_next  = (MY_POS == pos) ? data_reg : '0;
        end
    end

    always_ff @(posedge clk)
    begin
        data_reg  <= data_next;
        match_reg <= match_next;
        pick_reg  <= pick_next;
    end

    assign data  = data_reg;
    assign match = match_reg;
    assign pick  = pick_reg;

endmodule
`default_nettype wire

FILE: rtl/ale_row.sv
// Chain of list cells plus the reduction of their compare and pick
// outputs. Depends on ale_pkg and ale_cell.
`default_nettype none
module ale_row
    import ale_pkg::*;
#(
    parameter int CAPACITY = CAPACITY_DEF,
    parameter int POS_W    = $clog2(CAPACITY),
    parameter int CNT_W    = $clog2(CAPACITY + 1)
)
(
    input  wire logic                       clk,
    input  wire cell_ctl_t                  ctl,
    input  wire logic [POS_W-1:0]           pos,
    input  wire logic [CNT_W-1:0]           count,
    output logic                            match_any,
    output logic [POS_W-1:0]                found_pos,
    output logic signed [VALUE_W-1:0]       pick_or
);

    logic signed [VALUE_W-1:0] cell_data [CAPACITY];
    logic signed [VALUE_W-1:0] cell_pick [CAPACITY];
    logic                      cell_match [CAPACITY];

    // Row of cells, each wired to its neighbors
    for (genvar i = 0; i < CAPACITY; i++)
    begin : g_cell
        logic signed [VALUE_W-1:0] left_in, right_in;
        if (i == 0)
        begin : g_first
            assign left_in = '0;
        end
        else
        begin : g_left
            assign left_in = cell_data[i-1];
        end
        if (i == CAPACITY - 1)
        begin : g_last
            assign right_in = '0;
        end
        else
        begin : g_right
            assign right_in = cell_data[i+1];
        end

        ale_cell #(
            .POS_W (POS_W),
            .CNT_W (CNT_W),
            .IDX   (i)
        ) u_cell (
            .clk        (clk),
            .ctl        (ctl),
            .pos        (pos),
            .count      (count),
            .left_data  (left_in),
            .right_data (right_in),
            .data       (cell_data[i]),
            .match      (cell_match[i]),
            .pick       (cell_pick[i])
        );
    end

    // Lowest matching position
    always_comb
    begin
        found_pos = '0;
        match_any = 1'b0;
        for (int i = CAPACITY - 1; i >= 0; i--)
        begin
            if (cell_match[i])
            begin
                found_pos = POS_W'(i);
                match_any = 1'b1;
            end
        end
    end

    // Only the addressed cell picks a nonzero word
    always_comb
    begin
        pick_or = '0;
        for (int i = 0; i < CAPACITY; i++)
            pick_or = pick_or | cell_pick[i];
    end

endmodule
`default_nettype wire

FILE: rtl/array_list_engine.sv
// Array list engine: command decode, state machine and output register.
// One item at a time: exec step in the cell row, then done step, which builds
// the result from the row's match/pick outputs and waits for a free output
// register, then back to idle, where the next item is accepted.
// Reset: entry count cleared, capacity limit 64; cell contents undefined.
`default_nettype none
module array_list_engine
    import ale_pkg::*;
#(
    parameter int CAPACITY = CAPACITY_DEF
)
(
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire logic                in_valid,
    output logic                     in_ready,
    input  wire in_item_t            in_data,
    output logic                     out_valid,
    input  wire logic                out_ready,
    output out_item_t                out_data,
    input  wire logic                cfg_we,
    input  wire logic [LIMIT_W-1:0]  cfg_wdata
);

    localparam int POS_W = $clog2(CAPACITY);
    localparam int CNT_W = $clog2(CAPACITY + 1);
    localparam int LW    = (CNT_W > LIMIT_W) ? CNT_W : LIMIT_W;

    state_t                 state_reg, state_next;
    in_item_t               item_reg;
    logic [LIMIT_W-1:0]     limit_reg;
    logic [CNT_W-1:0]       count_reg, count_next;
    status_t                stat_reg, stat_next;
    logic                   remove_reg, search_reg;
    logic                   out_valid_reg, out_valid_next;
    out_item_t              out_reg, out_next;

    logic                   take_in, do_exec, do_load;
    cmd_t                   cmd;
    logic [LW-1:0]          lim, cnt_ext, idx_ext, pos_ext;
    logic                   full;
    cell_op_t               op;
    cell_ctl_t              ctl;
    logic                   match_any;
    logic [POS_W-1:0]       found_pos;
    logic signed [VALUE_W-1:0] pick_or;
    status_t                stat_final;

    // Next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            S_IDLE: if (in_valid) state_next = S_EXEC;
            S_EXEC: state_next = S_DONE;
            S_DONE: if (!out_valid_reg || out_ready) state_next = S_IDLE;
            default: state_next = S_IDLE;
        endcase
    end

    // State outputs
    always_comb
    begin
        in_ready = 1'b0;
        do_exec  = 1'b0;
        do_load  = 1'b0;
        case (state_reg)
            S_IDLE: in_ready = 1'b1;
            S_EXEC: do_exec  = 1'b1;
            S_DONE: do_load  = !out_valid_reg || out_ready;
            default: in_ready = 1'b0;
        endcase
    end

    assign take_in = in_valid && in_ready;
    assign cmd     = cmd_t'(item_reg.command);

    // Effective limit, clamped to 1..CAPACITY
    always_comb
    begin
        lim = LW'(limit_reg);
        if (lim == '0)
            lim = LW'(1);
        if (lim > LW'(CAPACITY))
            lim = LW'(CAPACITY);
    end

    assign cnt_ext = LW'(count_reg);
    assign idx_ext = LW'(item_reg.index);
    assign full    = cnt_ext >= lim;

    // Command decode: status, cell operation, position, new count
    always_comb
    begin
        stat_next  = STAT_OK;
        op         = OP_HOLD;
        pos_ext    = '0;
        count_next = count_reg;
        case (cmd)
            CMD_INSERT_AT, CMD_INSERT_FIRST, CMD_INSERT_LAST:
            begin
                if (full)
                    stat_next = STAT_FULL;
                else if (cmd == CMD_INSERT_AT && cnt_ext != '0 && idx_ext >= cnt_ext)
                    stat_next = STAT_BAD_INDEX;
                else
                begin
                    op         = OP_INSERT;
                    count_next = count_reg + CNT_W'(1);
                    if (cmd == CMD_INSERT_LAST)
                        pos_ext = cnt_ext;
                    else if (cmd == CMD_INSERT_AT && cnt_ext != '0)
                        pos_ext = idx_ext;
                end
            end
            CMD_REMOVE_AT, CMD_REMOVE_FIRST, CMD_REMOVE_LAST:
            begin
                if (cnt_ext == '0)
                    stat_next = STAT_EMPTY;
                else if (cmd == CMD_REMOVE_AT && idx_ext >= cnt_ext)
                    stat_next = STAT_BAD_INDEX;
                else
                begin
                    op         = OP_REMOVE;
                    count_next = count_reg - CNT_W'(1);
                    if (cmd == CMD_REMOVE_AT)
                        pos_ext = idx_ext;
                    else if (cmd == CMD_REMOVE_LAST)
                        pos_ext = cnt_ext - LW'(1);
                end
            end
            CMD_SEARCH:
            begin
                if (cnt_ext == '0)
                    stat_next = STAT_EMPTY;
            end
            CMD_CLEAR: count_next = '0;
            default: stat_next = STAT_OK;
        endcase
    end

    assign ctl.exec  = do_exec;
    assign ctl.op    = op;
    assign ctl.value = item_reg.value;

    ale_row #(
        .CAPACITY (CAPACITY),
        .POS_W    (POS_W),
        .CNT_W    (CNT_W)
    ) u_row (
        .clk       (clk),
        .ctl       (ctl),
        .pos       (pos_ext[POS_W-1:0]),
        .count     (count_reg),
        .match_any (match_any),
        .found_pos (found_pos),
        .pick_or   (pick_or)
    );

    // Result assembly after the row has compared and shifted
    always_comb
    begin
        stat_final = stat_reg;
        if (search_reg && stat_reg == STAT_OK)
            stat_final = match_any ? STAT_OK : STAT_NOT_FOUND;
        out_next.removed_value  = (remove_reg && stat_reg == STAT_OK) ? pick_or : '0;
        out_next.found_position = (search_reg && stat_final == STAT_OK)
                                  ? INDEX_W'(found_pos) : '0;
        out_next.status         = stat_final;
        out_next.entries_held   = HELD_W'(count_reg);
    end

    // Output valid flag
    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (do_load)
            out_valid_next = 1'b1;
        else if (out_ready)
            out_valid_next = 1'b0;
    end

    // Control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            limit_reg     <= LIMIT_RESET;
            count_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
            if (cfg_we)
                limit_reg <= cfg_wdata;
            if (do_exec)
                count_reg <= count_next;
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        if (take_in)
            item_reg <= in_data;
        if (do_exec)
        begin
            stat_reg   <= stat_next;
            remove_reg <= (cmd inside {CMD_REMOVE_AT, CMD_REMOVE_FIRST, CMD_REMOVE_LAST});
            search_reg <= (cmd == CMD_SEARCH);
        end
        if (do_load)
            out_reg <= out_next;
    end

    assign out_valid = out_valid_reg;
    assign out_data  = out_reg;

endmodule
`default_nettype wire

FILE: rtl/ale_checker.sv
// Port-level checks for the array list engine, bound to the top level.
// Depends on ale_pkg and array_list_engine.
`default_nettype none
module ale_checker
    import ale_pkg::*;
(
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire logic       in_valid,
    input  wire logic       in_ready,
    input  wire logic       out_valid,
    input  wire logic       out_ready,
    input  wire out_item_t  out_data
);

    // A stalled result item holds
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(out_data))
        else $error("result item changed while stalled");

    // One item in flight: no accept right after an accept
    a_one_item: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready |=> !in_ready)
        else $error("second item accepted while busy");

    // Empty status only on an empty list
    a_empty_cnt: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_data.status == STAT_EMPTY |-> out_data.entries_held == '0)
        else $error("empty status with entries held");

    // Removed value is zero unless the command succeeded
    a_removed_ok: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_data.status != STAT_OK |-> out_data.removed_value == '0)
        else $error("removed value on a failed command");

    // Found position is zero unless the status is ok
    a_found_ok: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_data.found_position != '0 |-> out_data.status == STAT_OK)
        else $error("found position on a failed command");

endmodule

bind array_list_engine ale_checker u_ale_checker (.*);
`default_nettype wire

FILE: tb/sv/array_list_checker.sv
// Checker for the array list engine: keeps its own copy of the list and
// the capacity limit, predicts each result item and compares in order.
// Depends on ale_pkg.
module array_list_checker
    import ale_pkg::*;
#(
    parameter int CAPACITY = CAPACITY_DEF
)
(
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire logic                in_valid,
    input  wire logic                in_ready,
    input  wire in_item_t            in_data,
    input  wire logic                out_valid,
    input  wire logic                out_ready,
    input  wire out_item_t           out_data,
    input  wire logic                cfg_we,
    input  wire logic [LIMIT_W-1:0]  cfg_wdata,
    output int                       fail_count,
    output int                       awaited,
    output int                       compared,
    output logic [4:0]               status_hits
);

    // Shadow of the list contents, its length and the limit register
    logic signed [VALUE_W-1:0]  shadow_vals [CAPACITY];
    int unsigned                shadow_len;
    logic [LIMIT_W-1:0]         shadow_limit;

    // Results predicted but not yet seen on the output, oldest first
    out_item_t                  due_results [$];
    out_item_t                  want;

    initial
    begin
        fail_count  = 0;
        awaited     = 0;
        compared    = 0;
        status_hits = '0;
    end

    // Limit register clamped to 1..CAPACITY; zero acts as one
    function automatic int unsigned room_limit();
        int unsigned lim;
        lim = 32'(shadow_limit);
        if (lim < 1)
            lim = 1;
        if (lim > CAPACITY)
            lim = CAPACITY;
        return lim;
    endfunction

    // Insert with upward shift; full is checked before anything else
    function automatic status_t list_insert(input int unsigned pos,
                                            input logic signed [VALUE_W-1:0] v);
        int unsigned j;
        if (shadow_len >= room_limit())
            return STAT_FULL;
        if (shadow_len == 0)
        begin
            shadow_vals[0] = v;
            shadow_len     = 1;
            return STAT_OK;
        end
        if (pos > shadow_len)
            return STAT_BAD_INDEX;
        for (j = shadow_len; j > pos; j--)
            shadow_vals[j] = shadow_vals[j - 1];
        shadow_vals[pos] = v;
        shadow_len++;
        return STAT_OK;
    endfunction

    // Remove with downward shift; the taken value only on success
    function automatic status_t list_remove(input int unsigned pos,
                                            output logic signed [VALUE_W-1:0] got);
        int unsigned j;
        got = '0;
        if (shadow_len == 0)
            return STAT_EMPTY;
        if (pos >= shadow_len)
            return STAT_BAD_INDEX;
        got = shadow_vals[pos];
        for (j = pos; j + 1 < shadow_len; j++)
            shadow_vals[j] = shadow_vals[j + 1];
        shadow_len--;
        return STAT_OK;
    endfunction

    // Apply one command to the shadow list and build its result item
    function automatic out_item_t predict_result(input in_item_t cmd_item);
        out_item_t                  res;
        logic signed [VALUE_W-1:0]  got;
        int unsigned                i;
        res = '0;
        got = '0;
        case (cmd_t'(cmd_item.command))
            CMD_INSERT_AT:
            begin
                // on a nonempty list, an index at or past the end is refused unless full wins first
                if (shadow_len > 0 && cmd_item.index >= shadow_len &&
                    shadow_len < room_limit())
                    res.status = STAT_BAD_INDEX;
                else
                    res.status = list_insert(32'(cmd_item.index), cmd_item.value);
            end
            CMD_INSERT_FIRST:
                res.status = list_insert(0, cmd_item.value);
            CMD_INSERT_LAST:
                res.status = list_insert(shadow_len, cmd_item.value);
            CMD_REMOVE_AT:
                res.status = list_remove(32'(cmd_item.index), got);
            CMD_REMOVE_FIRST:
                res.status = list_remove(0, got);
            CMD_REMOVE_LAST:
            begin
                if (shadow_len == 0)
                    res.status = STAT_EMPTY;
                else
                    res.status = list_remove(shadow_len - 1, got);
            end
            CMD_SEARCH:
            begin
                if (shadow_len == 0)
                    res.status = STAT_EMPTY;
                else
                begin
                    res.status = STAT_NOT_FOUND;
                    for (i = 0; i < shadow_len; i++)
                    begin
                        if (shadow_vals[i] == cmd_item.value)
                        begin
                            res.status         = STAT_OK;
                            res.found_position = INDEX_W'(i);
                            break;
                        end
                    end
                end
            end
            default:
            begin
                shadow_len = 0;
                res.status = STAT_OK;
            end
        endcase
        res.removed_value = got;
        res.entries_held  = HELD_W'(shadow_len);
        return res;
    endfunction

    task automatic check_field(input string name, input logic [31:0] exp_bits,
                               input logic [31:0] got_bits);
        if (got_bits !== exp_bits)
        begin
            fail_count++;
            $display("%0t: %s mismatch, expected %0h, got %0h",
                     $time, name, exp_bits, got_bits);
        end
    endtask

    // Config write, result compare, then command capture, all at the edge
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            shadow_len   = 0;
            shadow_limit = LIMIT_RESET;
            due_results.delete();
            awaited      = 0;
        end
        else
        begin
            if (cfg_we)
                shadow_limit = cfg_wdata;
            if (out_valid && out_ready)
            begin
                if (due_results.size() == 0)
                begin
                    fail_count++;
                    $display("%0t: result item with nothing awaited, got %p",
                             $time, out_data);
                end
                else
                begin
                    want = due_results.pop_front();
                    check_field("removed_value", want.removed_value,
                                out_data.removed_value);
                    check_field("found_position", 32'(want.found_position),
                                32'(out_data.found_position));
                    check_field("status", 32'(want.status), 32'(out_data.status));
                    check_field("entries_held", 32'(want.entries_held),
                                32'(out_data.entries_held));
                    compared++;
                    status_hits[want.status] = 1'b1;
                end
            end
            if (in_valid && in_ready)
                due_results.push_back(predict_result(in_data));
            awaited = due_results.size();
        end
    end

endmodule

FILE: tb/sv/tb_array_list_engine.sv
// Testbench top for the array list engine: clock, reset, command stimulus,
// limit writes and the verdict. Depends on ale_pkg and array_list_checker.
module tb_array_list_engine;
    import ale_pkg::*;

    // Slowest run is roughly 1000 items
    localparam int CYCLE_LIMIT = 200000;
    localparam int PHASES      = 8;
    localparam int PHASE_ITEMS = 110;

    logic                clk = 1'b0;
    logic                rst_n;
    logic                in_valid;
    logic                in_ready;
    in_item_t            in_data;
    logic                out_valid;
    logic                out_ready = 1'b0;
    out_item_t           out_data;
    logic                cfg_we;
    logic [LIMIT_W-1:0]  cfg_wdata;

    int                  fail_count;
    int                  awaited;
    int                  compared;
    logic [4:0]          status_hits;

    int                  cycles = 0;
    int                  sent;
    int                  limits_used;
    logic                quiet;
    logic signed [VALUE_W-1:0] recent_vals [$];

    always
    begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    array_list_engine #(.CAPACITY(CAPACITY_DEF)) dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .in_data   (in_data),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_data  (out_data),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata)
    );

    array_list_checker #(.CAPACITY(CAPACITY_DEF)) u_checker (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (in_valid),
        .in_ready    (in_ready),
        .in_data     (in_data),
        .out_valid   (out_valid),
        .out_ready   (out_ready),
        .out_data    (out_data),
        .cfg_we      (cfg_we),
        .cfg_wdata   (cfg_wdata),
        .fail_count  (fail_count),
        .awaited     (awaited),
        .compared    (compared),
        .status_hits (status_hits)
    );

    // Receiver stalls about a fifth of the time, never while quiet
    always @(negedge clk)
        out_ready <= quiet || ($urandom_range(99) >= 22);

    // Run-away guard
    always @(posedge clk)
    begin
        cycles++;
        if (cycles >= CYCLE_LIMIT)
        begin
            $display("array_list_engine regression: fail");
            $finish;
        end
    end

    // Present one item at a falling edge and hold it until accepted
    task automatic send_item(input in_item_t it);
        int gap;
        gap = 0;
        if (!quiet && $urandom_range(99) < 50)
            gap = $urandom_range(2, 1);
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        in_valid <= 1'b1;
        in_data  <= it;
        do
        begin
            @(posedge clk);
        end
        while (!in_ready);
        @(negedge clk);
        sent++;
        // remember inserted values so searches can hit
        if (it.command <= CMD_INSERT_LAST)
        begin
            recent_vals.push_back(it.value);
            if (recent_vals.size() > 16)
                void'(recent_vals.pop_front());
        end
    endtask

    task automatic send_cmd(input cmd_t c, input logic signed [VALUE_W-1:0] v,
                            input logic [INDEX_W-1:0] idx);
        in_item_t it;
        it.command = c;
        it.value   = v;
        it.index   = idx;
        send_item(it);
    endtask

    // Sender holds off until every awaited result has come back
    task automatic wait_idle();
        in_valid <= 1'b0;
        while (awaited != 0)
            @(negedge clk);
    endtask

    task automatic write_limit(input logic [LIMIT_W-1:0] lim);
        cfg_we    <= 1'b1;
        cfg_wdata <= lim;
        @(negedge clk);
        cfg_we    <= 1'b0;
        limits_used++;
    endtask

    // Mostly a small range for duplicates and hits, plus extremes and noise
    function automatic logic signed [VALUE_W-1:0] random_value();
        case ($urandom_range(9))
            0:       return 32'sh7fffffff;
            1:       return 32'sh80000000;
            2, 3:    return $urandom;
            default: return $signed($urandom_range(12)) - 3;
        endcase
    endfunction

    // Random command; growth mode favors inserts and never clears
    function automatic in_item_t random_item(input logic grow);
        in_item_t    it;
        int unsigned pick;
        it.value = random_value();
        if ($urandom_range(4) == 0)
            it.index = INDEX_W'($urandom_range(63));
        else
            it.index = INDEX_W'($urandom_range(11));
        pick = $urandom_range(99);
        if (grow && pick < 75)
            pick = pick % 43;
        else if (grow && pick >= 98)
            pick = 70;
        if (pick < 18)
            it.command = CMD_INSERT_AT;
        else if (pick < 28)
            it.command = CMD_INSERT_FIRST;
        else if (pick < 43)
            it.command = CMD_INSERT_LAST;
        else if (pick < 56)
            it.command = CMD_REMOVE_AT;
        else if (pick < 63)
            it.command = CMD_REMOVE_FIRST;
        else if (pick < 70)
            it.command = CMD_REMOVE_LAST;
        else if (pick < 98)
            it.command = CMD_SEARCH;
        else
            it.command = CMD_CLEAR;
        if (it.command == CMD_SEARCH && recent_vals.size() > 0 &&
            $urandom_range(9) < 7)
            it.value = recent_vals[$urandom_range(recent_vals.size() - 1)];
        return it;
    endfunction

    initial
    begin
        logic [LIMIT_W-1:0] phase_limits [PHASES];
        int p;
        int k;
        rst_n       = 1'b0;
        in_valid    = 1'b0;
        in_data     = '0;
        cfg_we      = 1'b0;
        cfg_wdata   = '0;
        quiet       = 1'b0;
        sent        = 0;
        limits_used = 0;
        // 127 clamps; 10 after the growth phase leaves the list over limit
        phase_limits = '{7'd127, 7'd3, 7'd1, 7'd64, 7'd10, 7'd64, 7'd2, 7'd45};

        repeat (11) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);
        write_limit(LIMIT_RESET);

        // Empty list: every remove and the search report empty
        send_cmd(CMD_SEARCH, 32'sd0, 6'd0);
        send_cmd(CMD_REMOVE_AT, 32'sd0, 6'd0);
        send_cmd(CMD_REMOVE_FIRST, 32'sd0, 6'd0);
        send_cmd(CMD_REMOVE_LAST, 32'sd0, 6'd0);
        // Insert into empty list ignores the index
        send_cmd(CMD_INSERT_AT, 32'sh7fffffff, 6'd63);
        send_cmd(CMD_INSERT_FIRST, 32'sh80000000, 6'd0);
        send_cmd(CMD_INSERT_LAST, -32'sd1, 6'd0);
        send_cmd(CMD_INSERT_LAST, 32'sd0, 6'd0);
        // Insert at or past the end is refused, then one inside the list is taken
        send_cmd(CMD_INSERT_AT, 32'sd9, 6'd4);
        send_cmd(CMD_INSERT_AT, 32'sd9, 6'd63);
        send_cmd(CMD_INSERT_AT, 32'sd5, 6'd2);
        // Search: hit on the last entry, a middle hit, a miss, lowest of two
        send_cmd(CMD_SEARCH, 32'sd0, 6'd0);
        send_cmd(CMD_SEARCH, -32'sd1, 6'd0);
        send_cmd(CMD_SEARCH, 32'sd123, 6'd0);
        send_cmd(CMD_INSERT_LAST, 32'sd5, 6'd0);
        send_cmd(CMD_SEARCH, 32'sd5, 6'd0);
        // Remove past the end, then each remove form
        send_cmd(CMD_REMOVE_AT, 32'sd0, 6'd6);
        send_cmd(CMD_REMOVE_AT, 32'sd0, 6'd1);
        send_cmd(CMD_REMOVE_FIRST, 32'sd0, 6'd0);
        send_cmd(CMD_REMOVE_LAST, 32'sd0, 6'd0);
        send_cmd(CMD_SEARCH, 32'sh7fffffff, 6'd0);
        send_cmd(CMD_CLEAR, 32'sd0, 6'd0);
        send_cmd(CMD_INSERT_AT, 32'sd1, 6'd0);

        // Zero limit acts as one: every insert form reports full
        wait_idle();
        write_limit(7'd0);
        send_cmd(CMD_INSERT_LAST, 32'sd2, 6'd0);
        send_cmd(CMD_INSERT_FIRST, 32'sd2, 6'd0);
        send_cmd(CMD_INSERT_AT, 32'sd2, 6'd0);
        send_cmd(CMD_REMOVE_LAST, 32'sd0, 6'd0);

        // Random phases, each under its own limit; list carries over
        for (p = 0; p < PHASES; p++)
        begin
            wait_idle();
            write_limit(phase_limits[p]);
            quiet <= (p == 5);
            for (k = 0; k < PHASE_ITEMS; k++)
                send_item(random_item(p == 3));
        end

        wait_idle();
        repeat (6) @(negedge clk);

        $display("Sent %0d commands under %0d limit settings, %0d results compared.",
                 sent, limits_used, compared);
        $display("Status codes reached (not found, bad index, empty, full, ok): %b",
                 status_hits);
        if (fail_count == 0 && awaited == 0)
            $display("array_list_engine regression: pass");
        else
            $display("array_list_engine regression: fail");
        $finish;
    end

endmodule

FILE: sim.f
rtl/ale_pkg.sv
rtl/ale_cell.sv
rtl/ale_row.sv
rtl/array_list_engine.sv
rtl/ale_checker.sv
tb/sv/array_list_checker.sv
tb/sv/tb_array_list_engine.sv
